FILE: sv/fpa_pkg.sv
`default_nettype none
package fpa_pkg;
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 8;
    localparam int DIV_BITS  = WORD_BITS + FRAC_BITS + 1;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_EQ = 4'd4, OP_NE = 4'd5, OP_LT = 4'd6, OP_GT = 4'd7,
        OP_LE = 4'd8, OP_GE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
        OP_INC = 4'd12, OP_DEC = 4'd13, OP_TO_INT = 4'd14, OP_FROM_INT = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIV0 = 2'd2
    } status_t;

    typedef struct packed {
        logic [3:0]                  req_type;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result_value;
        logic                        compare_true;
        logic [1:0]                  status;
    } rsp_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic [3:0]           op;
        logic                 neg;      // sign of the product or quotient
        logic                 sa;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic [WORD_BITS-1:0] ma;
        logic [WORD_BITS-1:0] mb;
    } cls_t;

    // Saturate a sign/magnitude value given as magnitude plus an overflow hint.
    function automatic logic [WORD_BITS:0] sat_pack(input logic neg,
        input logic big, input logic [WORD_BITS-1:0] mag);
        logic [WORD_BITS-1:0] limit;
        logic [WORD_BITS-1:0] m;
        logic                 ovf;
        begin
            limit = neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
            ovf = big || (mag > limit);
            m = ovf ? limit : mag;
            sat_pack = {ovf, (neg ? (~m + 1'b1) : m)};
        end
    endfunction
endpackage
`default_nettype wire

FILE: sv/fpa_if.sv
`default_nettype none
interface fpa_req_if;
    import fpa_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fpa_rsp_if;
    import fpa_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/fpa_front.sv
`default_nettype none
module fpa_front
    import fpa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fpa_req_if.sink   req,
    output logic      cls_valid,
    output cls_t      cls,
    input  wire logic cls_ready
);
    logic cls_valid_reg;
    cls_t cls_reg;
    cls_t cls_next;
    logic sa, sb;

    assign req.ready = !cls_valid_reg || cls_ready;
    assign cls_valid = cls_valid_reg;
    assign cls = cls_reg;

    always_comb
    begin
        sa = req.data.operand_a[WORD_BITS-1];
        sb = req.data.operand_b[WORD_BITS-1];
        cls_next.op = req.data.req_type;
        cls_next.sa = sa;
        cls_next.neg = sa ^ sb;
        cls_next.a = req.data.operand_a;
        cls_next.b = req.data.operand_b;
        cls_next.ma = sa ? (~req.data.operand_a + 1'b1) : req.data.operand_a;
        cls_next.mb = sb ? (~req.data.operand_b + 1'b1) : req.data.operand_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            cls_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cls_reg <= cls_next;
        end
    end
endmodule
`default_nettype wire

FILE: sv/fpa_fifo.sv
`default_nettype none
module fpa_fifo
    import fpa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  cls_t      in_data,
    output logic      in_ready,
    output logic      out_valid,
    output cls_t      out_data,
    input  wire logic out_ready
);
    // Two-entry queue.
    cls_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end
endmodule
`default_nettype wire

FILE: sv/fpa_back.sv
`default_nettype none
module fpa_back
    import fpa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  cls_t      in_data,
    output logic      in_ready,
    fpa_rsp_if.source rsp
);
    localparam int W = WORD_BITS;
    localparam int F = FRAC_BITS;
    localparam int NST = DIV_BITS + 2;   // stage 0 setup, divide steps, finish
    localparam int PW = 2 * W;

    // Pipeline: stage 0 prepares, DIV_BITS restoring steps, last stage rounds; the final pack follows it.
    logic           v_reg   [NST];
    cls_t           c_reg   [NST];
    logic [W+F:0]   num_reg [NST];   // dividend bits shifted out MSB first
    logic [W:0]     rem_reg [NST];
    logic [W+F:0]   quo_reg [NST];
    logic [PW-1:0]  prod_reg [NST];
    logic           out_valid_reg;
    rsp_t           out_reg;
    logic           adv;
    logic [W+1:0]   step [DIV_BITS];  // quotient bit and new remainder per step
    logic [W+F+1:0] qr;
    logic [PW:0]    pr;

    // One restoring step: shift in the next dividend bit and try to subtract.
    function automatic logic [W+1:0] div_step(input logic [W:0] rem,
        input logic nbit, input logic [W-1:0] d);
        logic [W+1:0] shifted;
        logic [W+1:0] trial;
        shifted = {rem, nbit};
        trial = shifted - {2'b00, d};
        return trial[W+1] ? {1'b0, shifted[W:0]} : {1'b1, trial[W:0]};
    endfunction

    assign adv = !out_valid_reg || rsp.ready;
    assign in_ready = adv;
    assign rsp.valid = out_valid_reg;
    assign rsp.data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            out_valid_reg <= v_reg[NST-1];
        end
    end

    // Divide steps, one quotient bit each.
    always_comb
    begin
        for (int i = 1; i <= DIV_BITS; i++)
            step[i-1] = div_step(rem_reg[i-1], num_reg[i-1][W+F], c_reg[i-1].mb);
    end

    // Rounding stage for the quotient and product.
    always_comb
    begin
        qr = {1'b0, quo_reg[DIV_BITS]} +
             (({rem_reg[DIV_BITS], 1'b0} >= {1'b0, {1'b0, c_reg[DIV_BITS].mb}})
              ? (W+F+2)'(1) : '0);
        pr = {1'b0, prod_reg[DIV_BITS]} + (PW+1)'(1 << (F-1));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 0: operands and the product.
            c_reg[0] <= in_data;
            num_reg[0] <= {1'b0, in_data.ma, {F{1'b0}}};
            rem_reg[0] <= '0;
            quo_reg[0] <= '0;
            prod_reg[0] <= PW'(in_data.ma) * PW'(in_data.mb);

            for (int i = 1; i <= DIV_BITS; i++)
            begin
                c_reg[i] <= c_reg[i-1];
                prod_reg[i] <= prod_reg[i-1];
                num_reg[i] <= {num_reg[i-1][W+F-1:0], 1'b0};
                quo_reg[i] <= {quo_reg[i-1][W+F-1:0], step[i-1][W+1]};
                rem_reg[i] <= step[i-1][W:0];
            end

            c_reg[NST-1] <= c_reg[DIV_BITS];
            quo_reg[NST-1] <= qr[W+F:0];
            prod_reg[NST-1] <= pr[PW:F] > ((PW+1-F))'({W{1'b1}})
                ? {{(PW-W){1'b0}}, {W{1'b1}}} | {1'b1, {(PW-1){1'b0}}}
                : PW'(pr[PW:F]);
            num_reg[NST-1] <= {(W+F+1){qr[W+F+1]}};
            rem_reg[NST-1] <= '0;
        end
    end

    // Final pack.
    cls_t           c;
    logic [W:0]     pk;
    logic [W:0]     s;
    rsp_t           r;
    logic           lt, gt, eq;
    always_comb
    begin
        c = c_reg[NST-1];
        r = '0;
        pk = '0;
        s = '0;
        eq = (c.a == c.b);
        lt = ($signed(c.a) < $signed(c.b));
        gt = ($signed(c.a) > $signed(c.b));
        case (op_t'(c.op))
            OP_ADD, OP_SUB, OP_INC, OP_DEC:
            begin
                if (c.op == OP_ADD)
                    s = {c.a[W-1], c.a} + {c.b[W-1], c.b};
                else if (c.op == OP_SUB)
                    s = {c.a[W-1], c.a} - {c.b[W-1], c.b};
                else if (c.op == OP_INC)
                    s = {c.a[W-1], c.a} + (W+1)'(1);
                else
                    s = {c.a[W-1], c.a} - (W+1)'(1);
                if (s[W] != s[W-1])
                begin
                    r.result_value = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                    r.status = ST_OVF;
                end
                else
                begin
                    r.result_value = s[W-1:0];
                end
            end
            OP_MUL:
            begin
                pk = sat_pack(c.neg, prod_reg[NST-1][PW-1], prod_reg[NST-1][W-1:0]);
                r.result_value = pk[W-1:0];
                r.status = pk[W] ? ST_OVF : ST_OK;
            end
            OP_DIV:
            begin
                if (c.mb == '0)
                begin
                    r.result_value = c.sa ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                    r.status = ST_DIV0;
                end
                else
                begin
                    pk = sat_pack(c.neg, num_reg[NST-1][0] || (quo_reg[NST-1][W+F:W] != '0),
                                  quo_reg[NST-1][W-1:0]);
                    r.result_value = pk[W-1:0];
                    r.status = pk[W] ? ST_OVF : ST_OK;
                end
            end
            OP_EQ: r.compare_true = eq;
            OP_NE: r.compare_true = !eq;
            OP_LT: r.compare_true = lt;
            OP_GT: r.compare_true = gt;
            OP_LE: r.compare_true = !gt;
            OP_GE: r.compare_true = !lt;
            OP_MIN: r.result_value = lt ? c.a : c.b;
            OP_MAX: r.result_value = gt ? c.a : c.b;
            OP_TO_INT:
            begin
                s = {1'b0, W'(c.ma >> F)};
                r.result_value = c.sa ? (~s[W-1:0] + 1'b1) : s[W-1:0];
            end
            OP_FROM_INT:
            begin
                pk = sat_pack(c.sa, (c.ma >> (W-F)) != '0, W'(c.ma << F));
                r.result_value = pk[W-1:0];
                r.status = pk[W] ? ST_OVF : ST_OK;
            end
            default: r = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= r;
        end
    end
endmodule
`default_nettype wire

FILE: sv/fixed_point_alu_q24_8.sv
`default_nettype none
// Channel | Role | Payload
// req     | sink   | req_type, operand_a, operand_b
// rsp     | source | result_value, compare_true, status
//
// One item is accepted per cycle unless a stalled result has backed up the queue; results follow in order.
// The divider is pipelined, one quotient bit per stage.
// rst_n clears all valid flags asynchronously; payload registers are not reset.
// A stalled result stops the back pipeline; the two-entry queue lets the front
// keep taking items until it fills.
module fixed_point_alu_q24_8
    import fpa_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    fpa_req_if.sink   req,
    fpa_rsp_if.source rsp
);
    logic f_valid, f_ready, q_valid, q_ready;
    cls_t f_data, q_data;

    // Front: registers the item and takes the operands apart into sign
    // and magnitude.
    fpa_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .cls_valid(f_valid), .cls(f_data), .cls_ready(f_ready)
    );

    fpa_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_data(f_data), .in_ready(f_ready),
        .out_valid(q_valid), .out_data(q_data), .out_ready(q_ready)
    );

    // Back: multiplier, pipelined divider and the saturating result stage.
    fpa_back u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_data(q_data), .in_ready(q_ready),
        .rsp(rsp)
    );
endmodule
`default_nettype wire

FILE: tb/fpa_result_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module fpa_result_checker
    import fpa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire logic req_ready,
    input  wire req_t req_data,
    input  wire logic rsp_valid,
    input  wire logic rsp_ready,
    input  wire rsp_t rsp_data,
    output int        fail_count,
    output int        pending_count
);
    localparam logic [WORD_BITS-1:0] MOST_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] MOST_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

    rsp_t expected_results[$];

    // Clamps a signed wide value to a word and flags overflow.
    function automatic rsp_t clamp_word(input logic signed [127:0] v);
        rsp_t r;
        begin
            r = '0;
            r.status = ST_OK;
            if (v > $signed({96'd0, MOST_POS})) begin
                r.result_value = MOST_POS;
                r.status = ST_OVF;
            end else if (v < -$signed(128'sd1 <<< (WORD_BITS-1))) begin
                r.result_value = MOST_NEG;
                r.status = ST_OVF;
            end else begin
                r.result_value = v[WORD_BITS-1:0];
            end
            return r;
        end
    endfunction

    // Divides magnitudes and rounds half away from zero, then applies the sign.
    function automatic logic signed [127:0] round_div(input logic signed [127:0] n,
        input logic signed [127:0] d);
        logic [127:0] mn;
        logic [127:0] md;
        logic [127:0] q;
        logic [127:0] rem;
        begin
            mn = n < 0 ? -n : n;
            md = d < 0 ? -d : d;
            q = mn / md;
            rem = mn % md;
            if (rem * 2 >= md)
                q = q + 1;
            return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
        end
    endfunction

    function automatic rsp_t alu_result(input req_t q);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] t;
        rsp_t r;
        begin
            a = q.operand_a;
            b = q.operand_b;
            r = '0;
            r.status = ST_OK;
            case (op_t'(q.req_type))
                OP_ADD: r = clamp_word(a + b);
                OP_SUB: r = clamp_word(a - b);
                OP_MUL: r = clamp_word(round_div(a * b, 128'sd1 <<< FRAC_BITS));
                OP_DIV:
                    if (b == 0) begin
                        r.result_value = a < 0 ? MOST_NEG : MOST_POS;
                        r.status = ST_DIV0;
                    end else begin
                        r = clamp_word(round_div(a <<< FRAC_BITS, b));
                    end
                OP_EQ: r.compare_true = a == b;
                OP_NE: r.compare_true = a != b;
                OP_LT: r.compare_true = a < b;
                OP_GT: r.compare_true = a > b;
                OP_LE: r.compare_true = a <= b;
                OP_GE: r.compare_true = a >= b;
                OP_MIN: r.result_value = a < b ? q.operand_a : q.operand_b;
                OP_MAX: r.result_value = a > b ? q.operand_a : q.operand_b;
                OP_INC: r = clamp_word(a + 1);
                OP_DEC: r = clamp_word(a - 1);
                OP_TO_INT:
                begin
                    t = (a < 0 ? -a : a) >>> FRAC_BITS;
                    r.result_value = a < 0 ? -t : t;
                end
                default: r = clamp_word(a <<< FRAC_BITS);
            endcase
            return r;
        end
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        int   errs;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            errs = 0;
            if (req_valid && req_ready)
                expected_results.push_back(alu_result(req_data));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result value=%0d", rsp_data.result_value);
                    errs++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_data.result_value !== want.result_value)
                    begin
                        $error("result_value expected %0d actual %0d",
                            want.result_value, rsp_data.result_value);
                        errs++;
                    end
                    if (rsp_data.compare_true !== want.compare_true)
                    begin
                        $error("compare_true expected %0d actual %0d",
                            want.compare_true, rsp_data.compare_true);
                        errs++;
                    end
                    if (rsp_data.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d",
                            want.status, rsp_data.status);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule
`default_nettype wire

FILE: tb/fixed_point_alu_q24_8_test.sv
`timescale 1ns / 100ps
`default_nettype none
module fixed_point_alu_q24_8_test;
    import fpa_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    // The drain margin is scaled from the depth of the divider pipeline.
    localparam int DRAIN_CYCLES = 2 * (WORD_BITS + FRAC_BITS + 5);

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    bit   calm_phase;

    fpa_req_if req ();
    fpa_rsp_if rsp ();

    fixed_point_alu_q24_8 i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source)
    );

    fpa_result_checker i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req.valid),
        .req_ready(req.ready),
        .req_data(req.data),
        .rsp_valid(rsp.valid),
        .rsp_ready(rsp.ready),
        .rsp_data(rsp.data),
        .fail_count(fail_count),
        .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The result side stalls in random bursts until the last part of the run,
    // where it always takes results.
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!calm_phase && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 5);
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end else begin
                rsp.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Drives one item and holds it until req.ready is seen high. An idle burst may
    // come first outside the calm phase; without one, valid stays high from one item to the next.
    task automatic send_item(input op_t op, input logic [WORD_BITS-1:0] a,
        input logic [WORD_BITS-1:0] b);
        int gap;
        begin
            if (!calm_phase && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 5);
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            req.valid <= 1'b1;
            req.data <= '{req_type: op, operand_a: a, operand_b: b};
            @(posedge clk);
            while (!req.ready) @(posedge clk);
        end
    endtask

    // Picks an operand that often lands on the edges, where saturation,
    // rounding and sign handling live.
    function automatic logic [WORD_BITS-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(WORD_BITS-1){1'b1}}};
            1: return {1'b1, {(WORD_BITS-1){1'b0}}};
            2: return WORD_BITS'($signed($urandom_range(0, 1024)) - 512);
            3: return WORD_BITS'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            4: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [WORD_BITS-1:0] max_w;
        logic [WORD_BITS-1:0] min_w;
        max_w = {1'b0, {(WORD_BITS-1){1'b1}}};
        min_w = {1'b1, {(WORD_BITS-1){1'b0}}};
        calm_phase = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items: extremes, every operation, divide by zero with
        // each dividend sign, overflow both ways, and rounding ties.
        send_item(OP_ADD, max_w, 32'd1);
        send_item(OP_SUB, min_w, 32'd1);
        send_item(OP_MUL, max_w, max_w);
        send_item(OP_MUL, min_w, min_w);
        send_item(OP_MUL, 32'd1, 32'd128);
        send_item(OP_MUL, -32'sd1, 32'd128);
        send_item(OP_DIV, 32'd5, 32'd0);
        send_item(OP_DIV, 32'd0, 32'd0);
        send_item(OP_DIV, min_w, 32'd0);
        send_item(OP_DIV, min_w, 32'd1);
        send_item(OP_DIV, 32'd1, 32'd512);
        send_item(OP_DIV, -32'sd1, -32'sd512);
        send_item(OP_EQ, min_w, min_w);
        send_item(OP_NE, min_w, max_w);
        send_item(OP_LT, min_w, max_w);
        send_item(OP_GT, max_w, min_w);
        send_item(OP_LE, 32'd7, 32'd7);
        send_item(OP_GE, -32'sd3, 32'd2);
        send_item(OP_MIN, 32'd9, 32'd9);
        send_item(OP_MAX, min_w, max_w);
        send_item(OP_INC, max_w, 32'd0);
        send_item(OP_DEC, min_w, 32'd0);
        send_item(OP_TO_INT, -32'sd257, 32'd0);
        send_item(OP_FROM_INT, max_w, 32'd0);
        send_item(OP_FROM_INT, min_w, 32'd0);

        // Hold off until the block has drained once.
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - 100)
                calm_phase = 1'b1;
            send_item(op_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
        end
        req.valid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
